// ===== hw/rtl/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types and constants of the text encoding detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ted_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PCT_W-1:0] HIGH_NULL_PCT_RST = 7'd70;
  localparam logic [PCT_W-1:0] LOW_NULL_PCT_RST  = 7'd10;

  // even or odd null count against half the length, so scale by 2 * 100
  localparam int unsigned NULL_SCALE = 200;

  localparam logic [15:0] BOM_LE      = 16'hFFFE;
  localparam logic [15:0] BOM_BE      = 16'hFEFF;
  localparam logic [15:0] BOM_U8_HEAD = 16'hEFBB;
  localparam logic [7:0]  BOM_U8_TAIL = 8'hBF;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic [7:0] U8_ASCII_MAX = 8'd127;
  localparam logic [7:0] U8_LEAD2_MIN = 8'd194;
  localparam logic [7:0] U8_LEAD2_MAX = 8'd223;
  localparam logic [7:0] U8_LEAD3_MIN = 8'd224;
  localparam logic [7:0] U8_LEAD3_MAX = 8'd239;
  localparam logic [7:0] U8_LEAD4_MIN = 8'd240;
  localparam logic [7:0] U8_LEAD4_MAX = 8'd244;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_NULL = 1'b0,
    CFG_LOW_NULL  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ENC_UNKNOWN  = 2'd0,
    ENC_UTF8     = 2'd1,
    ENC_UTF16_LE = 2'd2,
    ENC_UTF16_BE = 2'd3
  } encoding_e;

  typedef enum logic [1:0] {
    U8_VALID     = 2'd0,
    U8_INVALID   = 2'd1,
    U8_ZERO_LEAD = 2'd2
  } utf8_status_e;

endpackage

// ===== hw/rtl/ted_if.sv =====
// ----------------------------------------------------------------------------
// ted_byte_if / ted_enc_if
// Byte request channel and encoding verdict channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ted_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ted_enc_if;
  logic       valid;
  logic       ready;
  logic [1:0] encoding;

  modport source (output valid, output encoding, input ready);
  modport sink   (input valid, input encoding, output ready);
endinterface

// ===== hw/rtl/text_encoding_detector.sv =====
// ----------------------------------------------------------------------------
// text_encoding_detector
// Streams a buffer byte by byte and gives one encoding verdict per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte request per handshake with a last flag; the byte
//   flagged last closes the buffer. out_ch carries one verdict per buffer:
//   0 unknown, 1 UTF-8, 2 UTF-16 LE, 3 UTF-16 BE.
//   The thresholds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   (0 high null percent, 1 low null percent) while no buffer is in flight.
// Timing:
//   one byte per cycle sustained while in_ch.ready is high. After the last byte
//   is taken, the verdict passes byte register, state update, threshold
//   products and compare into the output register, then appears on out_ch.
// Reset:
//   clears the buffer state and the pipeline, thresholds return to 70 / 10.
// Stall:
//   while a verdict waits on out_ch, bytes keep flowing; in_ch.ready drops only
//   when a closing byte waits in the byte register behind three held verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_encoding_detector
  import ted_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PCT_W-1:0]     cfg_wdata_i,
  ted_byte_if.sink             in_ch,
  ted_enc_if.source            out_ch
);

  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned PW  = CW + PCT_W;
  localparam int unsigned SW  = CW + 8;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // thresholds
  logic [PCT_W-1:0] high_pct_q, low_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_pct_q <= HIGH_NULL_PCT_RST;
      low_pct_q  <= LOW_NULL_PCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HIGH_NULL: high_pct_q <= cfg_wdata_i;
        CFG_LOW_NULL:  low_pct_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_last_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s3_adv, s2_adv, s1_fire, in_acc;

  assign out_free = !out_v_q || out_ch.ready;
  assign s3_adv   = s3_v_q && out_free;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_adv   = s2_v_q && s3_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_fire  = s1_v_q && (!s1_last_q || s2_free);
  assign s1_free  = !s1_v_q || s1_fire;
  assign in_acc   = in_ch.valid && s1_free;

  assign in_ch.ready  = s1_free;
  assign out_ch.valid = out_v_q;

  // byte register
  logic [7:0] s1_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q    <= in_ch.valid;
      s1_last_q <= in_ch.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_ch.data_byte;
    end
  end

  // buffer state
  logic [CW-1:0]  pos_q, pos_n;
  logic [15:0]    mark_q, mark_n;
  logic [1:0]     pend_q, pend_n;
  utf8_status_e   status_q, status_n;
  logic [7:0]     hold_q, hold_n;
  logic           le_q, le_n, be_q, be_n, odd_q, odd_n;
  logic [CW-1:0]  evn_q, evn_n, odn_q, odn_n;

  always_comb begin
    pos_n    = (pos_q == CNT_MAX) ? pos_q : pos_q + CW'(1);
    mark_n   = mark_q;
    pend_n   = pend_q;
    status_n = status_q;
    hold_n   = hold_q;
    le_n     = le_q;
    be_n     = be_q;
    odd_n    = odd_q;
    evn_n    = evn_q;
    odn_n    = odn_q;

    if (pos_q == CW'(0)) begin
      mark_n = {s1_byte_q, 8'h00};
    end else if (pos_q == CW'(1)) begin
      mark_n = {mark_q[15:8], s1_byte_q};
    end else if (pos_q == CW'(2) && mark_q == BOM_U8_HEAD && s1_byte_q != BOM_U8_TAIL) begin
      mark_n = 16'h0000;
    end

    // utf-8 check
    if (status_q == U8_VALID) begin
      if (pend_q != 2'd0) begin
        if (s1_byte_q[7:6] != 2'b10) begin
          status_n = U8_INVALID;
        end else begin
          pend_n = pend_q - 2'd1;
        end
      end else if (s1_byte_q == 8'h00) begin
        status_n = U8_ZERO_LEAD;
      end else if (s1_byte_q <= U8_ASCII_MAX) begin
        pend_n = 2'd0;
      end else if (s1_byte_q inside {[U8_LEAD2_MIN:U8_LEAD2_MAX]}) begin
        pend_n = 2'd1;
      end else if (s1_byte_q inside {[U8_LEAD3_MIN:U8_LEAD3_MAX]}) begin
        pend_n = 2'd2;
      end else if (s1_byte_q inside {[U8_LEAD4_MIN:U8_LEAD4_MAX]}) begin
        pend_n = 2'd3;
      end else begin
        status_n = U8_INVALID;
      end
    end

    // byte pairs and null counts
    if (!odd_q) begin
      hold_n = s1_byte_q;
      if (s1_byte_q == 8'h00 && evn_q != CNT_MAX) begin
        evn_n = evn_q + CW'(1);
      end
      odd_n = 1'b1;
    end else begin
      if (hold_q == 8'h00 && (s1_byte_q == BYTE_LF || s1_byte_q == BYTE_CR)) begin
        be_n = 1'b1;
      end else if (s1_byte_q == 8'h00 && (hold_q == BYTE_LF || hold_q == BYTE_CR)) begin
        le_n = 1'b1;
      end
      if (s1_byte_q == 8'h00 && odn_q != CNT_MAX) begin
        odn_n = odn_q + CW'(1);
      end
      odd_n = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      mark_q   <= '0;
      pend_q   <= '0;
      status_q <= U8_VALID;
      hold_q   <= '0;
      le_q     <= 1'b0;
      be_q     <= 1'b0;
      odd_q    <= 1'b0;
      evn_q    <= '0;
      odn_q    <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        pos_q    <= '0;
        mark_q   <= '0;
        pend_q   <= '0;
        status_q <= U8_VALID;
        hold_q   <= '0;
        le_q     <= 1'b0;
        be_q     <= 1'b0;
        odd_q    <= 1'b0;
        evn_q    <= '0;
        odn_q    <= '0;
      end else begin
        pos_q    <= pos_n;
        mark_q   <= mark_n;
        pend_q   <= pend_n;
        status_q <= status_n;
        hold_q   <= hold_n;
        le_q     <= le_n;
        be_q     <= be_n;
        odd_q    <= odd_n;
        evn_q    <= evn_n;
        odn_q    <= odn_n;
      end
    end
  end

  // snapshot of the closed buffer
  logic [CW-1:0] s2_size_q, s2_evn_q, s2_odn_q;
  logic [15:0]   s2_mark_q;
  utf8_status_e  s2_status_q;
  logic          s2_le_q, s2_be_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_fire && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_fire && s1_last_q) begin
      s2_size_q   <= pos_n;
      s2_evn_q    <= evn_n;
      s2_odn_q    <= odn_n;
      s2_mark_q   <= mark_n;
      s2_status_q <= status_n;
      s2_le_q     <= le_n;
      s2_be_q     <= be_n;
    end
  end

  // early decisions and threshold products
  logic      early_hit;
  encoding_e early_enc;

  always_comb begin
    early_hit = 1'b1;
    early_enc = ENC_UNKNOWN;
    if (s2_size_q >= CW'(2) && s2_mark_q == BOM_LE) begin
      early_enc = ENC_UTF16_LE;
    end else if (s2_size_q >= CW'(2) && s2_mark_q == BOM_BE) begin
      early_enc = ENC_UTF16_BE;
    end else if (s2_size_q >= CW'(3) && s2_mark_q == BOM_U8_HEAD) begin
      early_enc = ENC_UTF8;
    end else if (s2_status_q == U8_VALID) begin
      early_enc = ENC_UTF8;
    end else if (s2_status_q == U8_ZERO_LEAD) begin
      early_enc = ENC_UNKNOWN;
    end else if (s2_le_q && !s2_be_q) begin
      early_enc = ENC_UTF16_LE;
    end else if (s2_be_q && !s2_le_q) begin
      early_enc = ENC_UTF16_BE;
    end else begin
      early_hit = 1'b0;
    end
  end

  logic          s3_hit_q;
  encoding_e     s3_enc_q;
  logic [SW-1:0] s3_ev_q, s3_od_q;
  logic [PW-1:0] s3_lo_q, s3_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_hit_q <= early_hit;
      s3_enc_q <= early_enc;
      s3_ev_q  <= SW'(s2_evn_q) * SW'(NULL_SCALE);
      s3_od_q  <= SW'(s2_odn_q) * SW'(NULL_SCALE);
      s3_lo_q  <= PW'(s2_size_q) * PW'(low_pct_q);
      s3_hi_q  <= PW'(s2_size_q) * PW'(high_pct_q);
    end
  end

  // null ratio compare
  logic [SW-1:0] lo_ext, hi_ext;
  encoding_e     final_enc;

  assign lo_ext = SW'(s3_lo_q);
  assign hi_ext = SW'(s3_hi_q);

  always_comb begin
    if (s3_hit_q) begin
      final_enc = s3_enc_q;
    end else if (s3_ev_q < lo_ext && s3_od_q > hi_ext) begin
      final_enc = ENC_UTF16_LE;
    end else if (s3_od_q < lo_ext && s3_ev_q > hi_ext) begin
      final_enc = ENC_UTF16_BE;
    end else begin
      final_enc = ENC_UNKNOWN;
    end
  end

  // output register
  encoding_e out_enc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s3_adv) begin
      out_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      out_enc_q <= final_enc;
    end
  end

  assign out_ch.encoding = out_enc_q;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (pos_q == '0 && status_q == U8_VALID && !odd_q))
    else $error("buffer state not cleared after closing byte");

  a_parity_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != CNT_MAX) |-> (odd_q == pos_q[0]))
    else $error("pair parity out of step with byte position");

  a_nulls_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evn_q <= pos_q && odn_q <= pos_q))
    else $error("null count above byte count");

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_adv |=> out_v_q)
    else $error("verdict lost between compare and output register");
`endif

endmodule
